@@ rtl/jsu_pkg.sv @@
package jsu_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_COUNT_W     = 24;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_UNTERM  = 3'd1;
    localparam logic [2:0] ERR_CTRL    = 3'd2;
    localparam logic [2:0] ERR_ESC_END = 3'd3;
    localparam logic [2:0] ERR_HEX     = 3'd4;
    localparam logic [2:0] ERR_ESC     = 3'd5;
    localparam logic [2:0] ERR_UTF8    = 3'd6;

    localparam logic [20:0] CP_REPLACE = 21'h00FFFD;

    // One piece of output work: a code point to encode, or a single item.
    typedef enum logic [2:0] {
        SK_NONE  = 3'd0,
        SK_CP    = 3'd1,
        SK_RAW   = 3'd2,
        SK_CLOSE = 3'd3,
        SK_ERR   = 3'd4
    } t_skind;

    typedef struct packed {
        t_skind      kind;
        logic        inc;
        logic [20:0] val;
        logic [2:0]  err;
    } t_seg;

    typedef struct packed {
        logic clr;
        t_seg seg0;
        t_seg seg1;
    } t_job;

endpackage

@@ rtl/json_string_unescaper_unit.sv @@
// Channel  | handshake        | payload
// input    | push / full      | i_in_byte, i_is_open, i_doc_end
// result   | empty / pop      | o_kind, o_data_byte, o_error_code, o_codepoint_count, o_last
//
// The front takes one byte per cycle while the job queue has room. The back sends
// one result byte per cycle while jobs wait and pop is high, and an item with results
// has one to six of them. An opening quote passes through the back with no result,
// and bytes inside escapes that give no result send no job to the back.
// Reset is synchronous and active low; it empties the queue and the output register.
// Either side may stall freely; the queue of QUEUE_DEPTH jobs keeps the front busy.
module json_string_unescaper_unit #(
    parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_is_open,
    input  logic        i_doc_end,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_error_code,
    output logic [23:0] o_codepoint_count,
    output logic        o_last
);

    logic          job_push, q_full, q_empty, q_pop;
    jsu_pkg::t_job job_in, job_out;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_in_byte  (i_in_byte),
        .i_is_open  (i_is_open),
        .i_doc_end  (i_doc_end),
        .i_q_full   (q_full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    jsu_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_job             (job_out),
        .o_q_pop           (q_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_kind            (o_kind),
        .o_data_byte       (o_data_byte),
        .o_error_code      (o_error_code),
        .o_codepoint_count (o_codepoint_count),
        .o_last            (o_last)
    );

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == jsu_pkg::KIND_ERR |-> o_last)
        else $error("error item not marked last");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind != jsu_pkg::KIND_ERR |-> o_error_code == jsu_pkg::ERR_NONE)
        else $error("error code on a non-error item");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("outputs not cleared by reset");

endmodule

@@ rtl/jsu_front.sv @@
module jsu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [7:0]      i_in_byte,
    input  logic            i_is_open,
    input  logic            i_doc_end,
    input  logic            i_q_full,
    output logic            o_job_push,
    output jsu_pkg::t_job   o_job
);

    typedef enum logic [7:0] {
        M_IDLE = 8'b0000_0001,
        M_STR  = 8'b0000_0010,
        M_ESC  = 8'b0000_0100,
        M_HEX  = 8'b0000_1000,
        M_UTF  = 8'b0001_0000,
        M_HIGH = 8'b0010_0000,
        M_HBS  = 8'b0100_0000,
        M_LHEX = 8'b1000_0000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [2:0]  r_hexn, n_hexn;
    logic [9:0]  r_high, n_high;
    logic [1:0]  r_rem, n_rem;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_hi, n_hi;

    logic acc;

    function automatic jsu_pkg::t_seg mk_seg(jsu_pkg::t_skind k, logic inc,
                                             logic [20:0] v, logic [2:0] e);
        jsu_pkg::t_seg s;
        s.kind = k;
        s.inc  = inc;
        s.val  = v;
        s.err  = e;
        return s;
    endfunction

    assign o_full = i_q_full;
    assign acc    = i_push && !i_q_full;

    always_comb begin
        jsu_pkg::t_seg none_seg;
        jsu_pkg::t_seg sb_seg, es_seg, fin_seg;
        t_mode         sb_mode, es_mode, fin_mode;
        logic [1:0]    sb_rem;
        logic [7:0]    sb_lo, sb_hi;
        logic          sb_clr, es_clr, is_u;
        logic [3:0]    d;
        logic          dok;
        logic [15:0]   hv;
        logic          hex_done, clr;
        logic [7:0]    c;

        c        = i_in_byte;
        none_seg = mk_seg(jsu_pkg::SK_NONE, 1'b0, 21'd0, jsu_pkg::ERR_NONE);

        // Plain string byte
        sb_seg  = none_seg;
        sb_mode = M_UTF;
        sb_rem  = 2'd0;
        sb_lo   = 8'h80;
        sb_hi   = 8'hBF;
        sb_clr  = 1'b0;
        if (c == 8'h22) begin
            sb_seg  = mk_seg(jsu_pkg::SK_CLOSE, 1'b0, 21'd0, jsu_pkg::ERR_NONE);
            sb_mode = M_IDLE;
            sb_clr  = 1'b1;
        end else if (c < 8'h20) begin
            sb_seg  = mk_seg(jsu_pkg::SK_ERR, 1'b0, 21'd0, jsu_pkg::ERR_CTRL);
            sb_mode = M_IDLE;
            sb_clr  = 1'b1;
        end else if (c == 8'h5C) begin
            sb_mode = M_ESC;
        end else if (c < 8'h80) begin
            sb_seg  = mk_seg(jsu_pkg::SK_RAW, 1'b1, {13'd0, c}, jsu_pkg::ERR_NONE);
            sb_mode = M_STR;
        end else begin
            sb_seg = mk_seg(jsu_pkg::SK_RAW, 1'b0, {13'd0, c}, jsu_pkg::ERR_NONE);
            if (c >= 8'hC2 && c <= 8'hDF) begin
                sb_rem = 2'd1;
            end else if (c == 8'hE0) begin
                sb_rem = 2'd2;
                sb_lo  = 8'hA0;
            end else if (c == 8'hED) begin
                sb_rem = 2'd2;
                sb_hi  = 8'h9F;
            end else if (c >= 8'hE1 && c <= 8'hEF) begin
                sb_rem = 2'd2;
            end else if (c == 8'hF0) begin
                sb_rem = 2'd3;
                sb_lo  = 8'h90;
            end else if (c >= 8'hF1 && c <= 8'hF3) begin
                sb_rem = 2'd3;
            end else if (c == 8'hF4) begin
                sb_rem = 2'd3;
                sb_hi  = 8'h8F;
            end else begin
                sb_seg  = mk_seg(jsu_pkg::SK_ERR, 1'b0, 21'd0, jsu_pkg::ERR_UTF8);
                sb_mode = M_IDLE;
                sb_clr  = 1'b1;
            end
        end

        // Byte after a backslash; a 'u' is handled by the caller
        is_u    = (c == 8'h75);
        es_mode = M_STR;
        es_clr  = 1'b0;
        es_seg  = mk_seg(jsu_pkg::SK_RAW, 1'b1, {13'd0, c}, jsu_pkg::ERR_NONE);
        case (c)
            8'h22, 8'h5C, 8'h2F: es_seg.val = {13'd0, c};
            8'h62:               es_seg.val = 21'h08;
            8'h66:               es_seg.val = 21'h0C;
            8'h6E:               es_seg.val = 21'h0A;
            8'h72:               es_seg.val = 21'h0D;
            8'h74:               es_seg.val = 21'h09;
            default: begin
                es_seg  = mk_seg(jsu_pkg::SK_ERR, 1'b0, 21'd0, jsu_pkg::ERR_ESC);
                es_mode = M_IDLE;
                es_clr  = 1'b1;
            end
        endcase

        // Hex digit
        dok = 1'b1;
        d   = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 4'(c - 8'h37);
        end else begin
            dok = 1'b0;
        end
        hv       = {r_hex[11:0], d};
        hex_done = (r_hexn == 3'd3);

        // Completed \u value taken on its own
        fin_seg  = none_seg;
        fin_mode = M_STR;
        if (hv >= 16'hD800 && hv <= 16'hDBFF) begin
            fin_mode = M_HIGH;
        end else if (hv >= 16'hDC00 && hv <= 16'hDFFF) begin
            fin_seg = mk_seg(jsu_pkg::SK_CP, 1'b1, jsu_pkg::CP_REPLACE, jsu_pkg::ERR_NONE);
        end else begin
            fin_seg = mk_seg(jsu_pkg::SK_CP, 1'b1, {5'd0, hv}, jsu_pkg::ERR_NONE);
        end

        n_mode = r_mode;
        n_hex  = r_hex;
        n_hexn = r_hexn;
        n_high = r_high;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_hi   = r_hi;
        clr    = 1'b0;
        o_job.clr  = 1'b0;
        o_job.seg0 = none_seg;
        o_job.seg1 = none_seg;

        if (i_doc_end) begin
            o_job.seg0 = mk_seg(jsu_pkg::SK_ERR, 1'b0, 21'd0, jsu_pkg::ERR_NONE);
            unique case (r_mode)
                M_STR, M_HIGH: o_job.seg0.err = jsu_pkg::ERR_UNTERM;
                M_ESC, M_HBS:  o_job.seg0.err = jsu_pkg::ERR_ESC_END;
                M_HEX, M_LHEX: o_job.seg0.err = jsu_pkg::ERR_HEX;
                M_UTF:         o_job.seg0.err = jsu_pkg::ERR_UTF8;
                default:       o_job.seg0 = none_seg;
            endcase
            n_mode = M_IDLE;
            clr    = 1'b1;
        end else if (i_is_open) begin
            o_job.clr = 1'b1;
            n_mode    = M_STR;
            clr       = 1'b1;
        end else begin
            unique case (r_mode)
                M_STR: begin
                    o_job.seg0 = sb_seg;
                    n_mode     = sb_mode;
                    n_rem      = sb_rem;
                    n_lo       = sb_lo;
                    n_hi       = sb_hi;
                    clr        = sb_clr;
                end
                M_ESC: begin
                    if (is_u) begin
                        n_mode = M_HEX;
                        n_hex  = 16'd0;
                        n_hexn = 3'd0;
                    end else begin
                        o_job.seg0 = es_seg;
                        n_mode     = es_mode;
                        clr        = es_clr;
                    end
                end
                M_HEX, M_LHEX: begin
                    if (!dok) begin
                        o_job.seg0 = mk_seg(jsu_pkg::SK_ERR, 1'b0, 21'd0, jsu_pkg::ERR_HEX);
                        n_mode     = M_IDLE;
                        clr        = 1'b1;
                    end else if (!hex_done) begin
                        n_hex  = hv;
                        n_hexn = r_hexn + 3'd1;
                    end else begin
                        n_hex  = 16'd0;
                        n_hexn = 3'd0;
                        if (r_mode == M_HEX) begin
                            o_job.seg0 = fin_seg;
                            n_mode     = fin_mode;
                            n_high     = hv[9:0];
                        end else if (hv >= 16'hDC00 && hv <= 16'hDFFF) begin
                            // Surrogate pair: 0x10000 plus the two ten-bit halves
                            o_job.seg0 = mk_seg(jsu_pkg::SK_CP, 1'b1,
                                                {1'b0, {r_high, hv[9:0]}} + 21'h10000,
                                                jsu_pkg::ERR_NONE);
                            n_mode     = M_STR;
                            n_high     = 10'd0;
                        end else begin
                            o_job.seg0 = mk_seg(jsu_pkg::SK_CP, 1'b1, jsu_pkg::CP_REPLACE,
                                                jsu_pkg::ERR_NONE);
                            o_job.seg1 = fin_seg;
                            n_mode     = fin_mode;
                            n_high     = (fin_mode == M_HIGH) ? hv[9:0] : 10'd0;
                        end
                    end
                end
                M_UTF: begin
                    if (c < r_lo || c > r_hi) begin
                        o_job.seg0 = mk_seg(jsu_pkg::SK_ERR, 1'b0, 21'd0, jsu_pkg::ERR_UTF8);
                        n_mode     = M_IDLE;
                        clr        = 1'b1;
                    end else begin
                        n_lo  = 8'h80;
                        n_hi  = 8'hBF;
                        n_rem = r_rem - 2'd1;
                        o_job.seg0 = mk_seg(jsu_pkg::SK_RAW, r_rem == 2'd1, {13'd0, c},
                                            jsu_pkg::ERR_NONE);
                        if (r_rem == 2'd1) begin
                            n_mode = M_STR;
                        end
                    end
                end
                M_HIGH: begin
                    if (c == 8'h5C) begin
                        n_mode = M_HBS;
                    end else begin
                        o_job.seg0 = mk_seg(jsu_pkg::SK_CP, 1'b1, jsu_pkg::CP_REPLACE,
                                            jsu_pkg::ERR_NONE);
                        o_job.seg1 = sb_seg;
                        n_high     = 10'd0;
                        n_mode     = sb_mode;
                        n_rem      = sb_rem;
                        n_lo       = sb_lo;
                        n_hi       = sb_hi;
                        clr        = sb_clr;
                    end
                end
                M_HBS: begin
                    if (is_u) begin
                        n_mode = M_LHEX;
                        n_hex  = 16'd0;
                        n_hexn = 3'd0;
                    end else begin
                        o_job.seg0 = mk_seg(jsu_pkg::SK_CP, 1'b1, jsu_pkg::CP_REPLACE,
                                            jsu_pkg::ERR_NONE);
                        o_job.seg1 = es_seg;
                        n_high     = 10'd0;
                        n_mode     = es_mode;
                        clr        = es_clr;
                    end
                end
                default: n_mode = M_IDLE;
            endcase
        end

        if (clr) begin
            n_hex  = 16'd0;
            n_hexn = 3'd0;
            n_high = 10'd0;
            n_rem  = 2'd0;
            n_lo   = 8'h80;
            n_hi   = 8'hBF;
        end

        o_job_push = acc && (o_job.clr || o_job.seg0.kind != jsu_pkg::SK_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_hex  <= 16'd0;
            r_hexn <= 3'd0;
            r_high <= 10'd0;
            r_rem  <= 2'd0;
            r_lo   <= 8'h80;
            r_hi   <= 8'hBF;
        end else if (acc) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_hexn <= n_hexn;
            r_high <= n_high;
            r_rem  <= n_rem;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
        end
    end

endmodule

@@ rtl/jsu_queue.sv @@
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output jsu_pkg::t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    jsu_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

@@ rtl/jsu_back.sv @@
module jsu_back #(
    parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  jsu_pkg::t_job i_job,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_data_byte,
    output logic [2:0]    o_error_code,
    output logic [23:0]   o_codepoint_count,
    output logic          o_last
);

    logic                   r_valid;
    logic [1:0]             r_kind;
    logic [7:0]             r_byte;
    logic [2:0]             r_err;
    logic [23:0]            r_ocnt;
    logic                   r_last;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_seg, n_seg;
    logic [1:0]             r_bi, n_bi;

    logic          adv, go, emit, seg_end, more;
    jsu_pkg::t_seg cur;
    logic [1:0]    len_m1;
    logic [7:0]    byte_val;
    logic [1:0]    kind_val;

    assign adv  = !r_valid || i_pop;
    assign go   = adv && !i_q_empty;
    assign cur  = r_seg ? i_job.seg1 : i_job.seg0;
    assign emit = go && !i_job.clr;

    always_comb begin
        logic [20:0] v;
        v        = cur.val;
        len_m1   = 2'd0;
        byte_val = v[7:0];
        kind_val = jsu_pkg::KIND_BYTE;
        case (cur.kind)
            jsu_pkg::SK_CP: begin
                if (v < 21'h80) begin
                    len_m1   = 2'd0;
                    byte_val = v[7:0];
                end else if (v < 21'h800) begin
                    len_m1 = 2'd1;
                    byte_val = (r_bi == 2'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
                end else if (v < 21'h10000) begin
                    len_m1 = 2'd2;
                    case (r_bi)
                        2'd0:    byte_val = {4'b1110, v[15:12]};
                        2'd1:    byte_val = {2'b10, v[11:6]};
                        default: byte_val = {2'b10, v[5:0]};
                    endcase
                end else begin
                    len_m1 = 2'd3;
                    case (r_bi)
                        2'd0:    byte_val = {5'b11110, v[20:18]};
                        2'd1:    byte_val = {2'b10, v[17:12]};
                        2'd2:    byte_val = {2'b10, v[11:6]};
                        default: byte_val = {2'b10, v[5:0]};
                    endcase
                end
            end
            jsu_pkg::SK_CLOSE: begin
                byte_val = 8'd0;
                kind_val = jsu_pkg::KIND_CLOSE;
            end
            jsu_pkg::SK_ERR: begin
                byte_val = 8'd0;
                kind_val = jsu_pkg::KIND_ERR;
            end
            default: ;
        endcase
    end

    assign seg_end = (r_bi == len_m1);
    assign more    = !r_seg && (i_job.seg1.kind != jsu_pkg::SK_NONE);
    assign o_q_pop = go && (i_job.clr || (seg_end && !more));

    always_comb begin
        n_count = r_count;
        n_seg   = r_seg;
        n_bi    = r_bi;
        if (go && i_job.clr) begin
            n_count = '0;
        end else if (emit) begin
            // The count goes up as the first byte of an inc segment leaves
            if (r_bi == 2'd0 && cur.inc && !(&r_count)) begin
                n_count = r_count + COUNT_WIDTH'(1);
            end
            if (!seg_end) begin
                n_bi = r_bi + 2'd1;
            end else if (more) begin
                n_seg = 1'b1;
                n_bi  = 2'd0;
            end else begin
                n_seg = 1'b0;
                n_bi  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            r_seg   <= 1'b0;
            r_bi    <= 2'd0;
        end else begin
            r_count <= n_count;
            r_seg   <= n_seg;
            r_bi    <= n_bi;
            if (adv) begin
                r_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_kind <= kind_val;
            r_byte <= byte_val;
            r_err  <= (cur.kind == jsu_pkg::SK_ERR) ? cur.err : jsu_pkg::ERR_NONE;
            r_ocnt <= 24'(n_count);
            r_last <= seg_end && !more;
        end
    end

    assign o_empty           = !r_valid;
    assign o_kind            = r_kind;
    assign o_data_byte       = r_byte;
    assign o_error_code      = r_err;
    assign o_codepoint_count = r_ocnt;
    assign o_last            = r_last;

endmodule

@@ tb/tb_json_string_unescaper_unit.sv @@
module tb_json_string_unescaper_unit;

    typedef enum logic [3:0] {
        PM_IDLE, PM_STR, PM_ESC, PM_HEX, PM_UTF, PM_HIGH, PM_HIGH_BS, PM_LOW_HEX
    } t_pmode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [2:0]  err;
        logic [23:0] cnt;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [7:0] b;
        logic       o;
        logic       e;
    } t_item;

    typedef struct packed {
        t_item item;
        logic  typed;
        t_res  res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        i_is_open;
    logic        i_doc_end;
    logic        empty;
    logic        pop;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_error_code;
    logic [23:0] o_codepoint_count;
    logic        o_last;

    json_string_unescaper_unit dut (.*);

    // Predictor state for the string being decoded.
    t_pmode      pm;
    logic [15:0] hexv;
    logic [2:0]  hexn;
    logic [9:0]  hi_half;
    logic [1:0]  utf_left;
    logic [7:0]  cont_lo, cont_hi;
    logic [23:0] cp_count;

    t_res  step_res[$];
    t_res  decoded_q[$];
    t_item stim[$];
    t_row  rows[$];
    int    mismatches;
    int    send_idle_pct, recv_idle_pct;
    bit    running;

    function automatic void put_res(logic [1:0] k, logic [7:0] b, logic [2:0] e);
        t_res r;
        if (step_res.size() >= 6) return;
        r.kind = k; r.data = b; r.err = e; r.cnt = cp_count; r.last = 1'b0;
        step_res = {step_res, r};
    endfunction

    function automatic void count_up();
        if (cp_count != 24'hFFFFFF) cp_count = cp_count + 24'd1;
    endfunction

    function automatic void clear_str();
        hexv = '0; hexn = '0; hi_half = '0; utf_left = '0;
        cont_lo = 8'h80; cont_hi = 8'hBF;
    endfunction

    function automatic void fail_str(logic [2:0] code);
        put_res(jsu_pkg::KIND_ERR, 8'h00, code);
        clear_str();
        pm = PM_IDLE;
    endfunction

    function automatic void send_cp(logic [20:0] cp);
        if (cp < 21'h80) begin
            put_res(jsu_pkg::KIND_BYTE, cp[7:0], jsu_pkg::ERR_NONE);
        end else if (cp < 21'h800) begin
            put_res(jsu_pkg::KIND_BYTE, {3'b110, cp[10:6]}, jsu_pkg::ERR_NONE);
            put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
        end else if (cp < 21'h10000) begin
            put_res(jsu_pkg::KIND_BYTE, {4'b1110, cp[15:12]}, jsu_pkg::ERR_NONE);
            put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]}, jsu_pkg::ERR_NONE);
            put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
        end else begin
            put_res(jsu_pkg::KIND_BYTE, {5'b11110, cp[20:18]}, jsu_pkg::ERR_NONE);
            put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[17:12]}, jsu_pkg::ERR_NONE);
            put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]}, jsu_pkg::ERR_NONE);
            put_res(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
        end
    endfunction

    function automatic void begin_utf(logic [1:0] n, logic [7:0] lo, logic [7:0] hi,
                                      logic [7:0] c);
        utf_left = n; cont_lo = lo; cont_hi = hi; pm = PM_UTF;
        put_res(jsu_pkg::KIND_BYTE, c, jsu_pkg::ERR_NONE);
    endfunction

    function automatic void plain_byte(logic [7:0] c);
        if (c == "\"") begin
            put_res(jsu_pkg::KIND_CLOSE, 8'h00, jsu_pkg::ERR_NONE); clear_str(); pm = PM_IDLE;
        end else if (c < 8'h20) fail_str(jsu_pkg::ERR_CTRL);
        else if (c == "\\") pm = PM_ESC;
        else if (c < 8'h80) begin
            count_up(); put_res(jsu_pkg::KIND_BYTE, c, jsu_pkg::ERR_NONE);
        end
        else if (c >= 8'hC2 && c <= 8'hDF) begin_utf(2'd1, 8'h80, 8'hBF, c);
        else if (c == 8'hE0) begin_utf(2'd2, 8'hA0, 8'hBF, c);
        else if (c == 8'hED) begin_utf(2'd2, 8'h80, 8'h9F, c);
        else if (c >= 8'hE1 && c <= 8'hEF) begin_utf(2'd2, 8'h80, 8'hBF, c);
        else if (c == 8'hF0) begin_utf(2'd3, 8'h90, 8'hBF, c);
        else if (c >= 8'hF1 && c <= 8'hF3) begin_utf(2'd3, 8'h80, 8'hBF, c);
        else if (c == 8'hF4) begin_utf(2'd3, 8'h80, 8'h8F, c);
        else fail_str(jsu_pkg::ERR_UTF8);
    endfunction

    function automatic void simple_esc(logic [7:0] b);
        count_up(); put_res(jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_NONE); pm = PM_STR;
    endfunction

    function automatic void escape_byte(logic [7:0] c);
        case (c)
            "\"", "\\", "/": simple_esc(c);
            "b": simple_esc(8'h08);
            "f": simple_esc(8'h0C);
            "n": simple_esc(8'h0A);
            "r": simple_esc(8'h0D);
            "t": simple_esc(8'h09);
            "u": begin
                hexv = '0; hexn = '0; pm = PM_HEX;
            end
            default: fail_str(jsu_pkg::ERR_ESC);
        endcase
    endfunction

    function automatic void hex_done(logic [15:0] v);
        hexv = '0; hexn = '0;
        if (v >= 16'hD800 && v <= 16'hDBFF) begin
            hi_half = v[9:0]; pm = PM_HIGH;
            return;
        end
        count_up();
        send_cp((v >= 16'hDC00 && v <= 16'hDFFF) ? jsu_pkg::CP_REPLACE : {5'd0, v});
        pm = PM_STR;
    endfunction

    function automatic void lone_surrogate();
        count_up(); send_cp(jsu_pkg::CP_REPLACE); hi_half = '0; pm = PM_STR;
    endfunction

    // Returns 1 once the fourth hex digit is in; a bad digit fails the string.
    function automatic bit hex_char(logic [7:0] c);
        logic [4:0] d;
        if (c >= "0" && c <= "9") d = 5'(c - 8'h30);
        else if (c >= "a" && c <= "f") d = 5'(c - 8'h57);
        else if (c >= "A" && c <= "F") d = 5'(c - 8'h37);
        else d = 5'd16;
        if (d > 5'd15) begin
            fail_str(jsu_pkg::ERR_HEX);
            return 1'b0;
        end
        hexv = {hexv[11:0], d[3:0]};
        hexn = hexn + 3'd1;
        return hexn >= 3'd4;
    endfunction

    function automatic void decode_item(t_item it);
        logic [15:0] v;
        step_res.delete();
        if (it.e) begin
            case (pm)
                PM_STR, PM_HIGH:        fail_str(jsu_pkg::ERR_UNTERM);
                PM_ESC, PM_HIGH_BS:     fail_str(jsu_pkg::ERR_ESC_END);
                PM_HEX, PM_LOW_HEX:     fail_str(jsu_pkg::ERR_HEX);
                PM_UTF:                 fail_str(jsu_pkg::ERR_UTF8);
                default:                pm = PM_IDLE;
            endcase
        end else if (it.o) begin
            clear_str(); cp_count = '0; pm = PM_STR;
        end else begin
            case (pm)
                PM_STR: plain_byte(it.b);
                PM_ESC: escape_byte(it.b);
                PM_HEX: if (hex_char(it.b)) hex_done(hexv);
                PM_UTF: begin
                    if (it.b < cont_lo || it.b > cont_hi) fail_str(jsu_pkg::ERR_UTF8);
                    else begin
                        cont_lo = 8'h80; cont_hi = 8'hBF;
                        utf_left = utf_left - 2'd1;
                        if (utf_left == 2'd0) begin
                            count_up(); pm = PM_STR;
                        end
                        put_res(jsu_pkg::KIND_BYTE, it.b, jsu_pkg::ERR_NONE);
                    end
                end
                PM_HIGH: begin
                    if (it.b == "\\") pm = PM_HIGH_BS;
                    else begin
                        lone_surrogate(); plain_byte(it.b);
                    end
                end
                PM_HIGH_BS: begin
                    if (it.b == "u") begin
                        hexv = '0; hexn = '0; pm = PM_LOW_HEX;
                    end else begin
                        lone_surrogate(); escape_byte(it.b);
                    end
                end
                PM_LOW_HEX: begin
                    if (hex_char(it.b)) begin
                        v = hexv;
                        if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                            hexv = '0; hexn = '0;
                            count_up();
                            send_cp(21'h10000 + {hi_half, v[9:0]});
                            hi_half = '0; pm = PM_STR;
                        end else begin
                            lone_surrogate(); hex_done(v);
                        end
                    end
                end
                default: pm = PM_IDLE;
            endcase
        end
        if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!running) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_res got, want;
        if (running && pop && !empty) begin
            got = {o_kind, o_data_byte, o_error_code, o_codepoint_count, o_last};
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", got);
            end else begin
                want = decoded_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    task automatic send(t_item it, logic typed, t_res r);
        push <= 1'b1;
        i_in_byte <= it.b; i_is_open <= it.o; i_doc_end <= it.e;
        do @(posedge i_clk); while (full);
        decode_item(it);
        if (typed) decoded_q = {decoded_q, r};
        else decoded_q = {decoded_q, step_res};
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic void row(int b, int o, int e);
        t_row r;
        r = '0; r.item = {8'(b), o[0], e[0]};
        rows = {rows, r};
    endfunction

    // Single result item of a string that has decoded nothing yet.
    function automatic void row_t(int b, int o, int e, logic [1:0] k, logic [2:0] code);
        t_row r;
        r = '0;
        r.item = {8'(b), o[0], e[0]}; r.typed = 1'b1;
        r.res = {k, 8'h00, code, 24'd0, 1'b1};
        rows = {rows, r};
    endfunction

    function automatic void add(int b, int o = 0, int e = 0);
        t_item it;
        it = {8'(b), o[0], e[0]};
        stim = {stim, it};
    endfunction

    function automatic void add_hex(int v);
        logic [3:0] d;
        add("\\"); add("u");
        for (int k = 3; k >= 0; k--) begin
            d = 4'(v >> (k * 4));
            if (d < 4'd10) add(int'(d) + 'h30);
            else if ($urandom_range(1) == 1) add(int'(d) + 'h57);
            else add(int'(d) + 'h37);
        end
    endfunction

    function automatic void add_utf8();
        case ($urandom_range(6))
            0: add($urandom_range(8'hC2, 8'hDF));
            1: begin add(8'hE0); add($urandom_range(8'hA0, 8'hBF)); end
            2: begin add(8'hED); add($urandom_range(8'h80, 8'h9F)); end
            3: begin add($urandom_range(8'hE1, 8'hEF)); add($urandom_range(8'h80, 8'hBF)); end
            4: begin
                add(8'hF0); add($urandom_range(8'h90, 8'hBF));
                add($urandom_range(8'h80, 8'hBF));
            end
            5: begin
                add(8'hF4); add($urandom_range(8'h80, 8'h8F));
                add($urandom_range(8'h80, 8'hBF));
            end
            default: begin
                add($urandom_range(8'hF1, 8'hF3)); add($urandom_range(8'h80, 8'hBF));
                add($urandom_range(8'h80, 8'hBF));
            end
        endcase
        add($urandom_range(8'h80, 8'hBF));
    endfunction

    // Mostly well-formed strings with random content, with some noise mixed in.
    function automatic void add_string();
        logic [7:0] simple [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
        if ($urandom_range(9) == 0) add($urandom_range(255));
        add("\"", 1, ($urandom_range(19) == 0) ? 1 : 0);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(11))
                0, 1, 2: add($urandom_range(8'h20, 8'h7F));
                3: begin add("\\"); add(int'(simple[$urandom_range(7)])); end
                4: add_hex($urandom_range('hFFFF));
                5: begin
                    add_hex($urandom_range('hD800, 'hDBFF));
                    add_hex($urandom_range('hDC00, 'hDFFF));
                end
                6: add_hex($urandom_range('hD800, 'hDFFF));
                7, 8: add_utf8();
                9: add($urandom_range(255));
                10: add(0, 0, 1);
                default: add($urandom_range(255), $urandom_range(1), 0);
            endcase
        end
        case ($urandom_range(9))
            0: add($urandom_range(255), 0, 1);
            1: add($urandom_range(255));
            default: add("\"");
        endcase
    endfunction

    initial begin
        t_res none;
        none = '0;
        push = 1'b0; pop = 1'b0; i_in_byte = 8'h00; i_is_open = 1'b0; i_doc_end = 1'b0;
        i_rst_n = 1'b0; running = 1'b0; mismatches = 0;
        send_idle_pct = 25; recv_idle_pct = 87;
        pm = PM_IDLE; clear_str(); cp_count = '0;

        row('hFF, 0, 0);                                // idle byte: ignored
        row("\"", 1, 0);                                // open: no result
        row_t('h01, 0, 0, jsu_pkg::KIND_ERR, jsu_pkg::ERR_CTRL);
        row("\"", 1, 0); row_t("\"", 0, 0, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
        row("\"", 1, 0); row_t('hFF, 0, 0, jsu_pkg::KIND_ERR, jsu_pkg::ERR_UTF8);
        row("\"", 1, 0); row("\\", 0, 0); row_t("q", 0, 0, jsu_pkg::KIND_ERR, jsu_pkg::ERR_ESC);
        row("\"", 1, 0); row("\\", 0, 0);
        row_t('h00, 0, 1, jsu_pkg::KIND_ERR, jsu_pkg::ERR_ESC_END);
        row("\"", 1, 0); row("\\", 0, 0); row("u", 0, 0);
        row_t("g", 0, 0, jsu_pkg::KIND_ERR, jsu_pkg::ERR_HEX);
        row("\"", 1, 1);                                 // end beats open
        row("\"", 1, 0); row('h7F, 0, 0); row('hF4, 0, 0); row('h8F, 0, 0);
        row('hBF, 0, 0); row('hBF, 0, 0);
        row("\"", 1, 0);                                 // open inside a string
        row_t('h00, 0, 1, jsu_pkg::KIND_ERR, jsu_pkg::ERR_UNTERM);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) send(rows[k].item, rows[k].typed, rows[k].res);
        // Surrogate pair; lone high surrogates before a plain byte and an escape; a lone low one.
        add("\"", 1); add_hex('hD83D); add_hex('hDE00); add_hex('hDBFF); add("x");
        add_hex('hDC00); add_hex('hD800); add("\\"); add("n"); add("\"");
        foreach (stim[k]) send(stim[k], 1'b0, none);
        stim.delete();
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 87 : 0;
            recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 25 : 0;
            while (stim.size() < 45) add_string();
            foreach (stim[k]) send(stim[k], 1'b0, none);
            stim.delete();
            drain();
        end

        if (mismatches == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescaper_unit.sv
tb/tb_json_string_unescaper_unit.sv
